// ===== sv/hcy_pkg.sv =====
// Shared constants for the RGB to HCY converter.
// Channel width, Rec.709 weights and the divider pipeline widths.
// No dependencies.
package hcy_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int Y_W = CHANNEL_BITS + 16;
  localparam int DIV_DW = Y_W;
  localparam int DIV_NW = Y_W + CHANNEL_BITS;
  localparam int SIDE_W = Y_W + CHANNEL_BITS + 1;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;
  localparam logic [Y_W-1:0] FULL = {CH_MAX, 16'h0000};

  localparam logic [15:0] W_RED = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE = 16'd4732;

endpackage

// ===== sv/hcy_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Expects the numerator's upper part below the divisor.
// Depends on hcy_pkg.
module hcy_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [hcy_pkg::DIV_NW-1:0]      n,
  input  logic [hcy_pkg::DIV_DW-1:0]      d,
  input  logic [hcy_pkg::SIDE_W-1:0]      side,
  output logic                            out_valid,
  output logic [hcy_pkg::CHANNEL_BITS-1:0] q,
  output logic [hcy_pkg::SIDE_W-1:0]      out_side
);

  localparam int B = hcy_pkg::CHANNEL_BITS;
  localparam int DW = hcy_pkg::DIV_DW;
  localparam int NW = hcy_pkg::DIV_NW;

  logic [DW-1:0]                rem [0:B];
  logic [B-1:0]                 lq  [0:B];
  logic [DW-1:0]                dd  [0:B];
  logic [hcy_pkg::SIDE_W-1:0]   sd  [0:B];
  logic [B:0]                   vv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= n[NW-1:B];
      lq[0]  <= n[B-1:0];
      dd[0]  <= d;
      sd[0]  <= side;
    end
  end

  for (genvar k = 1; k <= B; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      t    = {rem[k-1], lq[k-1][B-1]};
      diff = t - {1'b0, dd[k-1]};
      ge   = t >= {1'b0, dd[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= vv[k-1];
      end
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        lq[k]  <= {lq[k-1][B-2:0], ge};
        dd[k]  <= dd[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = vv[B];
  assign q = lq[B];
  assign out_side = sd[B];

endmodule

// ===== sv/hcy_front.sv =====
// Front stages: channel sort, chroma span, hue numerator and pixel luma.
// Feeds the hue divider.
// Depends on hcy_pkg.
module hcy_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] red,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] green,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] blue,
  output logic                             out_valid,
  output logic [hcy_pkg::DIV_NW-1:0]       n,
  output logic [hcy_pkg::DIV_DW-1:0]       d,
  output logic [hcy_pkg::SIDE_W-1:0]       side
);

  localparam int B = hcy_pkg::CHANNEL_BITS;
  localparam int YW = hcy_pkg::Y_W;
  localparam int NW = hcy_pkg::DIV_NW;
  localparam int DW = hcy_pkg::DIV_DW;
  localparam int SW = B + 5;
  localparam int AW = B + 3;

  localparam logic signed [3:0] OFS_BLUE_HI = -4'sd6;
  localparam logic signed [3:0] OFS_BLUE_LO = 4'sd4;
  localparam logic signed [3:0] OFS_GREEN_HI = 4'sd0;
  localparam logic signed [3:0] OFS_GREEN_LO = -4'sd2;

  logic [B-1:0]         px, py, qx, qy, qw, mn, c_w;
  logic signed [3:0]    pz, pw, qz;
  logic signed [SW-1:0] num;
  logic [SW-1:0]        num_abs;

  logic            a_valid;
  logic [B-1:0]    a_c;
  logic [AW-1:0]   a_abs;
  logic [YW-1:0]   a_pr, a_pg, a_pb;

  logic [YW-1:0]   y_sum;
  logic [NW-1:0]   hnum;

  always_comb begin
    if (green < blue) begin
      px = blue;
      py = green;
      pz = OFS_BLUE_HI;
      pw = OFS_BLUE_LO;
    end else begin
      px = green;
      py = blue;
      pz = OFS_GREEN_HI;
      pw = OFS_GREEN_LO;
    end
    if (red < px) begin
      qx = px;
      qz = pw;
      qw = red;
    end else begin
      qx = red;
      qz = pz;
      qw = px;
    end
    qy = py;
    mn = (qw < qy) ? qw : qy;
    c_w = qx - mn;
    num = $signed(SW'(qw)) - $signed(SW'(qy)) + qz * $signed(SW'(c_w));
    num_abs = num[SW-1] ? SW'(-num) : SW'(num);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      out_valid <= a_valid;
    end
    if (en) begin
      a_c   <= c_w;
      a_abs <= num_abs[AW-1:0];
      a_pr  <= YW'(hcy_pkg::W_RED) * YW'(red);
      a_pg  <= YW'(hcy_pkg::W_GREEN) * YW'(green);
      a_pb  <= YW'(hcy_pkg::W_BLUE) * YW'(blue);
      n     <= hnum + NW'(3 * NW'(a_c));
      d     <= DW'(6 * DW'(a_c));
      side  <= {(a_c == '0), y_sum, a_c};
    end
  end

  always_comb begin
    y_sum = a_pr + a_pg + a_pb;
    hnum  = (NW'(a_abs) << B) - NW'(a_abs);
  end

endmodule

// ===== sv/hcy_ramp.sv =====
// Middle stages: pure hue ramps, pure-hue luma, luma ratio operands.
// Takes the hue quotient and feeds the chroma divider.
// Depends on hcy_pkg.
module hcy_ramp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] hq,
  input  logic [hcy_pkg::SIDE_W-1:0]       in_side,
  output logic                             out_valid,
  output logic [hcy_pkg::DIV_NW-1:0]       n,
  output logic [hcy_pkg::DIV_DW-1:0]       d,
  output logic [hcy_pkg::SIDE_W-1:0]       side
);

  localparam int B = hcy_pkg::CHANNEL_BITS;
  localparam int YW = hcy_pkg::Y_W;
  localparam int NW = hcy_pkg::DIV_NW;
  localparam int HW = B + 5;
  localparam logic signed [HW-1:0] SM = signed'(HW'(hcy_pkg::CH_MAX));
  localparam logic signed [HW-1:0] SM2 = HW'(2 * SM);
  localparam logic signed [HW-1:0] SM3 = HW'(3 * SM);
  localparam logic signed [HW-1:0] SM4 = HW'(4 * SM);

  function automatic logic signed [HW-1:0] sabs(input logic signed [HW-1:0] v);
    return v[HW-1] ? HW'(-v) : v;
  endfunction

  function automatic logic [B-1:0] clampm(input logic signed [HW-1:0] v);
    logic [B-1:0] r;
    if (v[HW-1]) r = '0;
    else if (v > SM) r = hcy_pkg::CH_MAX;
    else r = v[B-1:0];
    return r;
  endfunction

  logic [B-1:0]         hue_w;
  logic signed [HW-1:0] h6;
  logic [YW:0]          luma_sum;

  logic [4:0]      vv;
  logic [B-1:0]    c_c, c_hr, c_hg, c_hb, c_hue, c_luma;
  logic [YW-1:0]   c_y;
  logic [B-1:0]    d_c, d_hue, d_luma;
  logic [YW-1:0]   d_y, d_pr, d_pg, d_pb;
  logic [B-1:0]    e_c, e_hue, e_luma;
  logic [YW-1:0]   e_fz, e_den;
  logic [B-1:0]    f_hue, f_luma;
  logic [YW-1:0]   f_den;
  logic [NW-1:0]   f_prod;

  logic [YW-1:0]   z_sum;
  logic            lt;
  logic [NW-1:0]   np;

  always_comb begin
    hue_w = in_side[hcy_pkg::SIDE_W-1] ? '0 : hq;
    h6 = HW'(6 * HW'(hue_w));
    luma_sum = (YW+1)'(in_side[B +: YW]) + (YW+1)'(32768);
    z_sum = d_pr + d_pg + d_pb;
    lt = d_y < z_sum;
    np = f_prod + NW'(f_den >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (en) begin
      vv <= {vv[3:0], in_valid};
    end
    if (en) begin
      c_c    <= in_side[B-1:0];
      c_y    <= in_side[B +: YW];
      c_hue  <= hue_w;
      c_luma <= luma_sum[16 +: B];
      c_hr   <= clampm(HW'(sabs(HW'(h6 - SM3)) - SM));
      c_hg   <= clampm(HW'(SM2 - sabs(HW'(h6 - SM2))));
      c_hb   <= clampm(HW'(SM2 - sabs(HW'(h6 - SM4))));

      d_c    <= c_c;
      d_y    <= c_y;
      d_hue  <= c_hue;
      d_luma <= c_luma;
      d_pr   <= YW'(hcy_pkg::W_RED) * YW'(c_hr);
      d_pg   <= YW'(hcy_pkg::W_GREEN) * YW'(c_hg);
      d_pb   <= YW'(hcy_pkg::W_BLUE) * YW'(c_hb);

      e_c    <= d_c;
      e_hue  <= d_hue;
      e_luma <= d_luma;
      e_fz   <= lt ? z_sum : hcy_pkg::FULL - z_sum;
      e_den  <= lt ? d_y : hcy_pkg::FULL - d_y;

      f_hue  <= e_hue;
      f_luma <= e_luma;
      f_den  <= e_den;
      f_prod <= NW'(e_c) * NW'(e_fz);

      n    <= np;
      d    <= f_den;
      side <= {(f_den == '0), (np[NW-1:B] >= f_den),
               {(hcy_pkg::SIDE_W - 2*B - 2){1'b0}}, f_luma, f_hue};
    end
  end

  assign out_valid = vv[4];

endmodule

// ===== sv/rgb_to_hcy_core.sv =====
// RGB to HCY converter top level: front, hue divider, ramps, chroma divider.
// Depends on hcy_pkg, hcy_front, hcy_div, hcy_ramp.
//
//  channel | handshake           | fields
//  input   | in_valid, in_stall   | red_in, green_in, blue_in
//  output  | out_valid, out_stall | hue_out, chroma_out, luma_out
//
// One pixel per cycle while the output is not held; the path runs through front, hue
// divider, ramps, chroma divider and output register, each divider one quotient bit per stage.
// Reset clears every valid bit; data registers are not reset.
// A held output freezes the whole pipeline; in_stall follows out_stall then.
module rgb_to_hcy_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] red_in,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] green_in,
  input  logic [hcy_pkg::CHANNEL_BITS-1:0] blue_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hcy_pkg::CHANNEL_BITS-1:0] hue_out,
  output logic [hcy_pkg::CHANNEL_BITS-1:0] chroma_out,
  output logic [hcy_pkg::CHANNEL_BITS-1:0] luma_out
);

  localparam int B = hcy_pkg::CHANNEL_BITS;

  logic                          en;
  logic                          f_valid, h_valid, r_valid, c_valid;
  logic [hcy_pkg::DIV_NW-1:0]    f_n, r_n;
  logic [hcy_pkg::DIV_DW-1:0]    f_d, r_d;
  logic [hcy_pkg::SIDE_W-1:0]    f_side, h_side, r_side, c_side;
  logic [B-1:0]                  h_q, c_q;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  hcy_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .red(red_in), .green(green_in), .blue(blue_in),
    .out_valid(f_valid), .n(f_n), .d(f_d), .side(f_side)
  );

  hcy_div u_hue_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .n(f_n), .d(f_d), .side(f_side),
    .out_valid(h_valid), .q(h_q), .out_side(h_side)
  );

  hcy_ramp u_ramp (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid),
    .hq(h_q), .in_side(h_side),
    .out_valid(r_valid), .n(r_n), .d(r_d), .side(r_side)
  );

  hcy_div u_chroma_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid),
    .n(r_n), .d(r_d), .side(r_side),
    .out_valid(c_valid), .q(c_q), .out_side(c_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
    if (en) begin
      hue_out  <= c_side[B-1:0];
      luma_out <= c_side[B +: B];
      if (c_side[hcy_pkg::SIDE_W-1]) begin
        chroma_out <= '0;
      end else if (c_side[hcy_pkg::SIDE_W-2]) begin
        chroma_out <= hcy_pkg::CH_MAX;
      end else begin
        chroma_out <= c_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_held_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output transaction");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_held_output_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(chroma_out) && $stable(hue_out)))
    else $error("held output transaction changed");
`endif

endmodule

// ===== test/rgb_to_hcy_core_test.sv =====
// Testbench for rgb_to_hcy_core: directed table, then random pixels under idle and stall phases.
// Each accepted result is compared against the table value or an in-bench HCY predictor.
// Depends on hcy_pkg and rgb_to_hcy_core.
module rgb_to_hcy_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = hcy_pkg::CHANNEL_BITS;
  localparam int MAX_CYCLES = 400000;

  typedef logic [CB-1:0] chan_t;
  typedef struct packed {
    chan_t hue;
    chan_t chroma;
    chan_t luma;
  } hcy_t;
  typedef struct {
    chan_t r, g, b;
    bit    known;
    hcy_t  res;
  } pixel_row_t;

  localparam chan_t CH_MAX = hcy_pkg::CH_MAX;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  chan_t red_in = '0, green_in = '0, blue_in = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  chan_t hue_out, chroma_out, luma_out;

  hcy_t  pending_hcy[$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  rgb_to_hcy_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic longint unsigned span_clip(longint v);
    longint m;
    m = longint'(CH_MAX);
    if (v < 0) return 0;
    if (v > m) return m;
    return v;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned rec709(longint unsigned r, longint unsigned g,
                                             longint unsigned b);
    return longint'(hcy_pkg::W_RED) * r + longint'(hcy_pkg::W_GREEN) * g +
           longint'(hcy_pkg::W_BLUE) * b;
  endfunction

  function automatic hcy_t predict_hcy(chan_t r_i, chan_t g_i, chan_t b_i);
    longint unsigned r, g, b, hi, mid, top, lo, mn, c, hue, full, y, z, chroma;
    longint off0, off1, off, num, m, h6, hr, hg, hb;
    hcy_t o;
    r = 64'(r_i); g = 64'(g_i); b = 64'(b_i);
    m = longint'(CH_MAX);
    if (g < b) begin
      hi = b; mid = g; off0 = -6; off1 = 4;
    end else begin
      hi = g; mid = b; off0 = 0; off1 = -2;
    end
    if (r < hi) begin
      top = hi; off = off1; lo = r;
    end else begin
      top = r; off = off0; lo = hi;
    end
    mn = lo < mid ? lo : mid;
    c = top - mn;
    num = longint'(lo) - longint'(mid) + off * longint'(c);
    hue = round_div(longint'(labs(num)) * m, 6 * c);
    if (hue > m) hue = m;
    h6 = 6 * longint'(hue);
    hr = span_clip(labs(h6 - 3 * m) - m);
    hg = span_clip(2 * m - labs(h6 - 2 * m));
    hb = span_clip(2 * m - labs(h6 - 4 * m));
    full = m * 65536;
    y = rec709(r, g, b);
    z = rec709(hr, hg, hb);
    if (y < z) chroma = round_div(c * z, y);
    else chroma = round_div(c * (full - z), full - y);
    if (chroma > m) chroma = m;
    o.hue = chan_t'(hue);
    o.chroma = chan_t'(chroma);
    o.luma = chan_t'((y + 32768) >> 16);
    return o;
  endfunction

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    hcy_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hcy.size() == 0) begin
        $error("unexpected transaction hue=%0d chroma=%0d luma=%0d",
               hue_out, chroma_out, luma_out);
        errors++;
      end else begin
        e = pending_hcy.pop_front();
        if (hue_out !== e.hue) begin
          $error("hue_out expected %0d actual %0d", e.hue, hue_out); errors++;
        end
        if (chroma_out !== e.chroma) begin
          $error("chroma_out expected %0d actual %0d", e.chroma, chroma_out); errors++;
        end
        if (luma_out !== e.luma) begin
          $error("luma_out expected %0d actual %0d", e.luma, luma_out); errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycles > MAX_CYCLES) begin
      $display("rgb_to_hcy_core_test: errors");
      $finish;
    end
  end

  task automatic send_pixel(chan_t r, chan_t g, chan_t b, bit known, hcy_t res);
    hcy_t p;
    p = predict_hcy(r, g, b);
    if (known && p !== res) begin
      $error("table row %0d/%0d/%0d: predictor hue=%0d chroma=%0d luma=%0d", r, g, b,
             p.hue, p.chroma, p.luma);
      errors++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_hcy.push_back(known ? res : p);
  endtask

  function automatic chan_t rand_chan();
    case ($urandom_range(5))
      0: return '0;
      1: return CH_MAX;
      2: return chan_t'($urandom_range(255));
      3: return CH_MAX - chan_t'($urandom_range(255));
      default: return chan_t'($urandom);
    endcase
  endfunction

  initial begin
    pixel_row_t table_rows[$];
    chan_t r, g, b;
    int n;
    hcy_t none;
    none = '0;
    table_rows = '{
      '{16'd0, 16'd0, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd0}},
      '{CH_MAX, CH_MAX, CH_MAX, 1'b1, '{16'd0, 16'd0, CH_MAX}},
      '{16'd32768, 16'd32768, 16'd32768, 1'b1, '{16'd0, 16'd0, 16'd32768}},
      '{CH_MAX, 16'd0, 16'd0, 1'b0, none},
      '{16'd0, CH_MAX, 16'd0, 1'b0, none},
      '{16'd0, 16'd0, CH_MAX, 1'b0, none},
      '{CH_MAX, CH_MAX, 16'd0, 1'b0, none},
      '{16'd0, CH_MAX, CH_MAX, 1'b0, none},
      '{CH_MAX, 16'd0, CH_MAX, 1'b0, none},
      '{16'd1, 16'd0, 16'd0, 1'b0, none},
      '{16'd0, 16'd0, 16'd1, 1'b0, none},
      '{CH_MAX, CH_MAX, 16'd65534, 1'b0, none},
      '{CH_MAX, 16'd65534, CH_MAX, 1'b0, none},
      '{16'd100, 16'd200, 16'd300, 1'b0, none},
      '{16'd300, 16'd200, 16'd100, 1'b0, none},
      '{16'd200, 16'd300, 16'd100, 1'b0, none},
      '{16'd65000, 16'd600, 16'd300, 1'b0, none},
      '{16'd300, 16'd600, 16'd65000, 1'b0, none},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, none},
      '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, none}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i])
      send_pixel(table_rows[i].r, table_rows[i].g, table_rows[i].b,
                 table_rows[i].known, table_rows[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 12 : 79) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 12 : 79) : 0;
      for (n = 0; n < 335; n++) begin
        r = rand_chan(); g = rand_chan(); b = rand_chan();
        case ($urandom_range(7))
          0: g = r;
          1: b = g;
          2: begin g = r; b = r; end
          default: ;
        endcase
        send_pixel(r, g, b, 1'b0, none);
        if (n == 100) begin
          // hold until the pipeline drains
          in_valid <= 1'b0;
          while (pending_hcy.size() != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_hcy.size() != 0) @(posedge clk);
    repeat (2 * CB + 20) @(posedge clk);
    if (errors == 0 && pending_hcy.size() == 0) begin
      $display("rgb_to_hcy_core_test: clean");
    end else begin
      $display("rgb_to_hcy_core_test: errors");
    end
    $finish;
  end
endmodule

// ===== rgb_to_hcy_core.f =====
sv/hcy_pkg.sv
sv/hcy_div.sv
sv/hcy_front.sv
sv/hcy_ramp.sv
sv/rgb_to_hcy_core.sv
test/rgb_to_hcy_core_test.sv
